>>> rtl/core/bsls_pkg.sv
`timescale 1ns / 1ps
// bsls_pkg: sizes, payload structs, codes and helper functions of the banded solver.
// No dependencies; every module of the solver but bsls_ram imports it.
`default_nettype none
package bsls_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_BAND   = 7;
   localparam int HALF_MAX   = (MAX_BAND - 1) / 2;

   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int N_W        = $clog2(MAX_ROWS + 1);
   localparam int COL_W      = $clog2(MAX_BAND);
   localparam int HALF_W     = $clog2(HALF_MAX + 1);
   localparam int CNT_W      = $clog2(HALF_MAX + 2);
   localparam int BAND_DEPTH = MAX_ROWS * MAX_BAND;
   localparam int BADDR_W    = $clog2(BAND_DEPTH);

   localparam int VAL_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int SUM_W      = PROD_W - FRAC_W + 1;
   localparam int DIV_STEPS  = VAL_W + FRAC_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam int SIZE_W     = 7;
   localparam int BW_W       = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_SYSTEM_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_WIDTH  = 1'b1;

   localparam logic [1:0] CMD_WRITE_BAND = 2'd0;
   localparam logic [1:0] CMD_WRITE_RHS  = 2'd1;
   localparam logic [1:0] CMD_SOLVE      = 2'd2;

   typedef struct packed {
      logic [1:0]              command;
      logic [ROW_W-1:0]        row_index;
      logic [COL_W-1:0]        band_column;
      logic signed [VAL_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] solution_value;
      logic [ROW_W-1:0]        solution_row;
      logic                    last_row;
      logic                    status;
   } rsp_type;

   typedef enum logic [1:0] {OP_BAND, OP_RHS, OP_SOLVE} op_type;

   typedef struct packed {
      op_type                  op;
      logic [BADDR_W-1:0]      band_addr;
      logic [ROW_W-1:0]        row;
      logic signed [VAL_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef enum logic [1:0] {MK_BAND, MK_RHS_LO, MK_RHS_UP} mac_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LP_BR, ST_LP_PIV_RD, ST_LP_PIV_CAP, ST_LP_D, ST_LP_A_RD, ST_LP_A_CAP,
      ST_LP_DIV, ST_LP_K,
      ST_UP_BR, ST_UP_PIV_RD, ST_UP_PIV_CAP, ST_UP_D, ST_UP_A_RD, ST_UP_A_CAP,
      ST_UP_DIV,
      ST_MAC_SRC, ST_MAC_DST, ST_MAC_MUL, ST_MAC_WR,
      ST_DV_BR, ST_DV_PIV_RD, ST_DV_PIV_CAP, ST_DV_DIV,
      ST_OUT_RD, ST_OUT_SEND
   } state_type;

   function automatic logic [BADDR_W-1:0] band_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      band_addr = BADDR_W'(row) * BADDR_W'(MAX_BAND) + BADDR_W'(col);
   endfunction

   // Clamp a widened sum into the signed value range.
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
      if (v[SUM_W-1:VAL_W-1] == {(SUM_W-VAL_W+1){v[SUM_W-1]}}) begin
         sat_val = v[VAL_W-1:0];
      end else if (v[SUM_W-1]) begin
         sat_val = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(VAL_W-1){1'b1}}};
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/bsls_ram.sv
`timescale 1ns / 1ps
// bsls_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

>>> rtl/core/bsls_div.sv
`timescale 1ns / 1ps
// bsls_div: bit-serial Q16.16 divider, optional negation, saturated quotient.
// Depends on bsls_pkg.
`default_nettype none
module bsls_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [bsls_pkg::VAL_W-1:0] num,
   input  wire logic signed [bsls_pkg::VAL_W-1:0] den,
   input  wire logic                            negate,
   output logic                                 done,
   output logic signed [bsls_pkg::VAL_W-1:0]    quot
);
   import bsls_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    fin_ff, fin_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIV_STEPS-1:0]    num_ff, num_in;
   logic [VAL_W-1:0]        den_ff, den_in;
   logic [VAL_W:0]          rem_ff, rem_in;
   logic [DIV_STEPS-1:0]    q_ff, q_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] quot_ff, quot_in;
   logic [VAL_W-1:0]        mag_num, mag_den;
   logic [VAL_W:0]          rem_sh;
   logic                    ge;

   always_comb begin
      mag_num = num[VAL_W-1] ? VAL_W'(-num) : VAL_W'(num);
      mag_den = den[VAL_W-1] ? VAL_W'(-den) : VAL_W'(den);
      rem_sh  = {rem_ff[VAL_W-1:0], num_ff[DIV_STEPS-1]};
      ge      = rem_sh >= {1'b0, den_ff};

      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = {mag_num, {FRAC_W{1'b0}}};
         den_in  = mag_den;
         rem_in  = '0;
         q_in    = '0;
         neg_in  = num[VAL_W-1] ^ den[VAL_W-1] ^ negate;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         q_in   = {q_ff[DIV_STEPS-2:0], ge};
         num_in = {num_ff[DIV_STEPS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      if (fin_ff) begin
         if (neg_ff) begin
            if (|q_ff[DIV_STEPS-1:VAL_W] || (q_ff[VAL_W-1] && |q_ff[VAL_W-2:0])) begin
               quot_in = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
               quot_in = -$signed(q_ff[VAL_W-1:0]);
            end
         end else begin
            if (|q_ff[DIV_STEPS-1:VAL_W-1]) begin
               quot_in = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
               quot_in = q_ff[VAL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

>>> rtl/core/bsls_front.sv
`timescale 1ns / 1ps
// bsls_front: accepts request transactions, decodes them and queues them for the back end.
// Depends on bsls_pkg.
`default_nettype none
module bsls_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire bsls_pkg::req_type  req_data,
   input  wire logic               pop,
   output bsls_pkg::head_type      head
);
   import bsls_pkg::*;

   item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   item_type             item;
   logic                 keep;
   logic                 push;

   // Decode: drop unknown commands and out-of-range writes here.
   always_comb begin
      item.band_addr = band_addr(req_data.row_index, req_data.band_column);
      item.row       = req_data.row_index;
      item.value     = req_data.entry_value;
      item.op        = OP_SOLVE;
      keep           = 1'b0;
      unique case (req_data.command)
         CMD_WRITE_BAND: begin
            item.op = OP_BAND;
            keep    = (int'(req_data.band_column) < MAX_BAND) &&
                      (int'(req_data.row_index) < MAX_ROWS);
         end
         CMD_WRITE_RHS: begin
            item.op = OP_RHS;
            keep    = int'(req_data.row_index) < MAX_ROWS;
         end
         CMD_SOLVE: begin
            item.op = OP_SOLVE;
            keep    = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall  = cnt_ff == Q_CNT_W'(Q_DEPTH);
   assign push       = req_valid && !req_stall && keep;
   assign head.valid = cnt_ff != '0;
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/bsls_back.sv
`timescale 1ns / 1ps
// bsls_back: executes queued loads and the solve sequence over the band and rhs RAMs.
// Depends on bsls_pkg, bsls_ram and bsls_div.
`default_nettype none
module bsls_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bsls_pkg::head_type            head,
   output logic                               pop,
   input  wire logic [bsls_pkg::N_W-1:0]      sys_n,
   input  wire logic [bsls_pkg::HALF_W-1:0]   half,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output bsls_pkg::rsp_type                  rsp_data
);
   import bsls_pkg::*;

   state_type               state_ff, state_in;
   mac_kind_type            kind_ff, kind_in;
   logic [N_W-1:0]          br_ff, br_in;
   logic [CNT_W-1:0]        d_ff, d_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic signed [VAL_W-1:0] piv_ff, piv_in;
   logic signed [VAL_W-1:0] rm_ff, rm_in;
   logic signed [VAL_W-1:0] src_ff, src_in;
   logic signed [VAL_W-1:0] dst_ff, dst_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                    err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    band_we, rhs_we;
   logic [BADDR_W-1:0]      band_waddr, band_raddr;
   logic [ROW_W-1:0]        rhs_waddr, rhs_raddr;
   logic [VAL_W-1:0]        band_wdata, rhs_wdata, band_rd, rhs_rd;

   logic                    div_start, div_neg, div_done;
   logic signed [VAL_W-1:0] div_a, div_p, div_q;

   logic [ROW_W-1:0]        br_row, dst_row, up_row, lo_row;
   logic [COL_W-1:0]        diag_col, src_col, dst_col, lo_a_col, up_a_col;
   logic signed [VAL_W-1:0] mac_rd, mac_val;
   logic signed [SUM_W-1:0] mac_sum;
   logic                    lo_ok, k_ok, up_ok, br_last, out_free;

   bsls_ram #(.WIDTH(VAL_W), .DEPTH(BAND_DEPTH)) u_band_ram (
      .clock (clock),
      .we    (band_we),
      .waddr (band_waddr),
      .wdata (band_wdata),
      .raddr (band_raddr),
      .rdata (band_rd)
   );

   bsls_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_rhs_ram (
      .clock (clock),
      .we    (rhs_we),
      .waddr (rhs_waddr),
      .wdata (rhs_wdata),
      .raddr (rhs_raddr),
      .rdata (rhs_rd)
   );

   bsls_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_a),
      .den    (div_p),
      .negate (div_neg),
      .done   (div_done),
      .quot   (div_q)
   );

   // Row and band column arithmetic for the current step.
   always_comb begin
      br_row   = br_ff[ROW_W-1:0];
      lo_row   = ROW_W'(br_ff + N_W'(d_ff));
      up_row   = ROW_W'(br_ff - N_W'(d_ff));
      dst_row  = (kind_ff == MK_RHS_UP) ? up_row : lo_row;
      diag_col = COL_W'(half);
      src_col  = COL_W'(half) + COL_W'(k_ff);
      dst_col  = COL_W'(half) - COL_W'(d_ff) + COL_W'(k_ff);
      lo_a_col = COL_W'(half) - COL_W'(d_ff);
      up_a_col = COL_W'(half) + COL_W'(d_ff);
      mac_rd   = (kind_ff == MK_BAND) ? band_rd : rhs_rd;
      mac_sum  = SUM_W'(dst_ff) + SUM_W'(prod_ff >>> FRAC_W);
      mac_val  = sat_val(mac_sum);
      lo_ok    = (d_ff <= CNT_W'(half)) &&
                 (({1'b0, br_ff} + (N_W+1)'(d_ff)) < {1'b0, sys_n});
      k_ok     = (k_ff <= CNT_W'(half)) &&
                 (({1'b0, br_ff} + (N_W+1)'(k_ff)) < {1'b0, sys_n});
      up_ok    = (d_ff <= CNT_W'(half)) && (N_W'(d_ff) <= br_ff);
      br_last  = br_ff == (sys_n - 1'b1);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      div_start = 1'b0;
      div_a     = (state_ff == ST_DV_PIV_CAP) ? rhs_rd : band_rd;
      div_p     = (state_ff == ST_DV_PIV_CAP) ? band_rd : piv_ff;
      div_neg   = state_ff != ST_DV_PIV_CAP;
      case (state_ff)
         ST_LP_A_CAP, ST_UP_A_CAP: div_start = 1'b1;
         ST_DV_PIV_CAP:            div_start = band_rd != '0;
         default:                  div_start = 1'b0;
      endcase
   end

   always_comb begin
      band_raddr = '0;
      rhs_raddr  = (state_ff == ST_MAC_DST) ? dst_row : br_row;
      case (state_ff)
         ST_LP_PIV_RD, ST_UP_PIV_RD, ST_DV_PIV_RD: band_raddr = band_addr(br_row, diag_col);
         ST_LP_A_RD: band_raddr = band_addr(lo_row, lo_a_col);
         ST_UP_A_RD: band_raddr = band_addr(up_row, up_a_col);
         ST_MAC_SRC: band_raddr = band_addr(br_row, src_col);
         ST_MAC_DST: band_raddr = band_addr(lo_row, dst_col);
         default:    band_raddr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      br_in        = br_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      piv_in       = piv_ff;
      rm_in        = rm_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      prod_in      = prod_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      band_we      = 1'b0;
      band_waddr   = head.item.band_addr;
      band_wdata   = head.item.value;
      rhs_we       = 1'b0;
      rhs_waddr    = head.item.row;
      rhs_wdata    = head.item.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.item.op)
                  OP_BAND: band_we = 1'b1;
                  OP_RHS:  rhs_we  = 1'b1;
                  OP_SOLVE: begin
                     err_in   = 1'b0;
                     br_in    = '0;
                     state_in = ST_LP_BR;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end

         // Forward elimination: band rows and rhs below the diagonal.
         ST_LP_BR: begin
            if ((br_ff + 1'b1) < sys_n) begin
               state_in = ST_LP_PIV_RD;
            end else begin
               br_in    = sys_n - 1'b1;
               state_in = ST_UP_BR;
            end
         end
         ST_LP_PIV_RD: state_in = ST_LP_PIV_CAP;
         ST_LP_PIV_CAP: begin
            piv_in   = band_rd;
            d_in     = CNT_W'(1);
            state_in = ST_LP_D;
         end
         ST_LP_D: begin
            if (lo_ok) begin
               if (piv_ff == '0) begin
                  err_in = 1'b1;
                  d_in   = d_ff + 1'b1;
               end else begin
                  state_in = ST_LP_A_RD;
               end
            end else begin
               br_in    = br_ff + 1'b1;
               state_in = ST_LP_BR;
            end
         end
         ST_LP_A_RD:  state_in = ST_LP_A_CAP;
         ST_LP_A_CAP: state_in = ST_LP_DIV;
         ST_LP_DIV: begin
            if (div_done) begin
               rm_in    = div_q;
               k_in     = '0;
               state_in = ST_LP_K;
            end
         end
         ST_LP_K: begin
            kind_in  = k_ok ? MK_BAND : MK_RHS_LO;
            state_in = ST_MAC_SRC;
         end

         // Back substitution on the rhs only.
         ST_UP_BR: begin
            if (br_ff != '0) begin
               state_in = ST_UP_PIV_RD;
            end else begin
               state_in = ST_DV_BR;
            end
         end
         ST_UP_PIV_RD: state_in = ST_UP_PIV_CAP;
         ST_UP_PIV_CAP: begin
            piv_in   = band_rd;
            d_in     = CNT_W'(1);
            state_in = ST_UP_D;
         end
         ST_UP_D: begin
            if (up_ok) begin
               if (piv_ff == '0) begin
                  err_in = 1'b1;
                  d_in   = d_ff + 1'b1;
               end else begin
                  state_in = ST_UP_A_RD;
               end
            end else begin
               br_in    = br_ff - 1'b1;
               state_in = ST_UP_BR;
            end
         end
         ST_UP_A_RD:  state_in = ST_UP_A_CAP;
         ST_UP_A_CAP: state_in = ST_UP_DIV;
         ST_UP_DIV: begin
            if (div_done) begin
               rm_in    = div_q;
               kind_in  = MK_RHS_UP;
               state_in = ST_MAC_SRC;
            end
         end

         // Shared multiply-accumulate: dst += rm * src.
         ST_MAC_SRC: state_in = ST_MAC_DST;
         ST_MAC_DST: begin
            src_in   = mac_rd;
            state_in = ST_MAC_MUL;
         end
         ST_MAC_MUL: begin
            dst_in   = mac_rd;
            prod_in  = PROD_W'(rm_ff) * PROD_W'(src_ff);
            state_in = ST_MAC_WR;
         end
         ST_MAC_WR: begin
            band_waddr = band_addr(lo_row, dst_col);
            band_wdata = mac_val;
            rhs_waddr  = dst_row;
            rhs_wdata  = mac_val;
            unique case (kind_ff)
               MK_BAND: begin
                  band_we  = 1'b1;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_LP_K;
               end
               MK_RHS_LO: begin
                  rhs_we   = 1'b1;
                  d_in     = d_ff + 1'b1;
                  state_in = ST_LP_D;
               end
               MK_RHS_UP: begin
                  rhs_we   = 1'b1;
                  d_in     = d_ff + 1'b1;
                  state_in = ST_UP_D;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // Divide each rhs entry by its pivot; a zero pivot writes zero and flags an error.
         ST_DV_BR: begin
            if (br_ff < sys_n) begin
               state_in = ST_DV_PIV_RD;
            end else begin
               br_in    = '0;
               state_in = ST_OUT_RD;
            end
         end
         ST_DV_PIV_RD: state_in = ST_DV_PIV_CAP;
         ST_DV_PIV_CAP: begin
            if (band_rd == '0) begin
               err_in    = 1'b1;
               rhs_we    = 1'b1;
               rhs_waddr = br_row;
               rhs_wdata = '0;
               br_in     = br_ff + 1'b1;
               state_in  = ST_DV_BR;
            end else begin
               state_in = ST_DV_DIV;
            end
         end
         ST_DV_DIV: begin
            if (div_done) begin
               rhs_we    = 1'b1;
               rhs_waddr = br_row;
               rhs_wdata = div_q;
               br_in     = br_ff + 1'b1;
               state_in  = ST_DV_BR;
            end
         end

         // Stream the solution out.
         ST_OUT_RD: state_in = ST_OUT_SEND;
         ST_OUT_SEND: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.solution_value = rhs_rd;
               rsp_in.solution_row   = br_row;
               rsp_in.last_row       = br_last;
               rsp_in.status         = err_ff;
               if (br_last) begin
                  state_in = ST_IDLE;
               end else begin
                  br_in    = br_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
      kind_ff <= kind_in;
      br_ff   <= br_in;
      d_ff    <= d_in;
      k_ff    <= k_in;
      piv_ff  <= piv_in;
      rm_ff   <= rm_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/core/band_storage_linear_solve.sv
`timescale 1ns / 1ps
// band_storage_linear_solve: top level of the banded Gaussian elimination solver.
// Depends on bsls_pkg, bsls_front and bsls_back (which holds bsls_ram and bsls_div).
//
//   channel | ports                      | moves
//   --------+----------------------------+----------------------------------------
//   request | req_valid/req_stall/req_*  | load band entry, load rhs entry, solve
//   result  | rsp_valid/rsp_stall/rsp_*  | one x element per row after a solve
//   config  | csr_we/csr_index/csr_wdata | system_size, band_width
//
// The back end writes each load to its RAM as it pops it; a two-entry queue takes request transactions
// while a solve runs or a result waits. Each elimination factor and each final quotient comes
// from a bit-serial divider (48 quotient bits, then a saturating step, then the presented
// result), and each update runs four multiply-accumulate steps around the single band RAM
// read port, after a column step during forward elimination.
// Reset is synchronous; the RAMs need no clearing pass. A stalled result holds in the
// output register while the queue keeps filling.
`default_nettype none
module band_storage_linear_solve (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire bsls_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output bsls_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [bsls_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bsls_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bsls_pkg::*;

   logic [SIZE_W-1:0] size_ff;
   logic [BW_W-1:0]   bw_ff;
   logic [N_W-1:0]    sys_n;
   logic [HALF_W-1:0] half;
   logic [BW_W-2:0]   half_raw;
   head_type          head;
   logic              pop;

   // Config registers; the user must write them only while the solver is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(MAX_ROWS);
         bw_ff   <= BW_W'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYSTEM_SIZE: size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_BAND_WIDTH:  bw_ff   <= csr_wdata[BW_W-1:0];
            default:         size_ff <= size_ff;
         endcase
      end
   end

   // Clamp n into 1..MAX_ROWS, and h so that the band fits in a stored row.
   always_comb begin
      half_raw = bw_ff[BW_W-1:1];
      if (size_ff == '0) begin
         sys_n = N_W'(1);
      end else if (int'(size_ff) > MAX_ROWS) begin
         sys_n = N_W'(MAX_ROWS);
      end else begin
         sys_n = N_W'(size_ff);
      end
      if (int'(half_raw) > HALF_MAX) begin
         half = HALF_W'(HALF_MAX);
      end else begin
         half = HALF_W'(half_raw);
      end
   end

   bsls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head)
   );

   bsls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .sys_n     (sys_n),
      .half      (half),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The queue is never drained when empty.
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   // The last-row flag marks exactly row n-1.
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (N_W'(rsp_data.solution_row) == (sys_n - 1'b1))))
      else $error("last_row does not match row n-1");

   // Every emitted row lies inside the system.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (N_W'(rsp_data.solution_row) < sys_n))
      else $error("solution row beyond system size");
endmodule
`default_nettype wire
